// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the gait phase contact scheduler.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/gpcs_pkg.sv =====
// Package of the gait phase contact scheduler: widths, register codes and
// the structs passed between the top level and the per-leg units. No dependencies.
`default_nettype none

package gpcs_pkg;

  localparam int unsigned NumLegs   = 4;   // legs carried on the result channel
  localparam int unsigned LegCount  = 4;   // legs actually scheduled (1..4)

  localparam int unsigned TickDtW   = 24;
  localparam int unsigned StepFreqW = 16;
  localparam int unsigned DutyW     = 17;
  localparam int unsigned OffsetW   = 18;
  localparam int unsigned PhaseW    = 17;
  localparam int unsigned IncW      = 16;
  localparam int unsigned ProdW     = TickDtW + StepFreqW;
  localparam int unsigned IncShift  = 20;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 18;

  localparam logic [PhaseW:0]         OneCycle       = (PhaseW+1)'(65536);
  localparam logic [IncW-1:0]         IncMax         = '1;
  localparam logic signed [OffsetW-1:0] OffsetDisabled = '1;

  localparam logic [StepFreqW-1:0]    StepFreqReset  = StepFreqW'(4096);
  localparam logic [DutyW-1:0]        DutyReset      = DutyW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    RegStepFreq = 3'd0,
    RegDuty     = 3'd1,
    RegOffset0  = 3'd2,
    RegOffset1  = 3'd3,
    RegOffset2  = 3'd4,
    RegOffset3  = 3'd5
  } cfg_reg_e;

  // Per-tick control from the increment stage to every leg unit.
  typedef struct packed {
    logic            upd;   // a tick leaves the increment stage this cycle
    logic            clr;   // configuration write: clear phases, set start mode
    logic            run;
    logic [IncW-1:0] inc;
  } leg_ctrl_t;

  typedef struct packed {
    logic              contact;
    logic [PhaseW-1:0] phase;
  } leg_res_t;

endpackage

`default_nettype wire

// ===== design/gpcs_intf.sv =====
// Handshake interfaces of the gait phase contact scheduler: tick input,
// result output and configuration write channel. Depends on gpcs_pkg.
`default_nettype none

interface gpcs_tick_if;
  import gpcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [TickDtW-1:0] tick_dt;
  logic               run;
  modport source (output valid, tick_dt, run, input ready);
  modport sink   (input valid, tick_dt, run, output ready);
endinterface

interface gpcs_res_if;
  import gpcs_pkg::*;
  logic              valid;
  logic              ready;
  logic              contact_leg0;
  logic              contact_leg1;
  logic              contact_leg2;
  logic              contact_leg3;
  logic [PhaseW-1:0] phase_leg0;
  logic [PhaseW-1:0] phase_leg1;
  logic [PhaseW-1:0] phase_leg2;
  logic [PhaseW-1:0] phase_leg3;
  modport source (output valid, contact_leg0, contact_leg1, contact_leg2, contact_leg3,
                  phase_leg0, phase_leg1, phase_leg2, phase_leg3, input ready);
  modport sink   (input valid, contact_leg0, contact_leg1, contact_leg2, contact_leg3,
                  phase_leg0, phase_leg1, phase_leg2, phase_leg3, output ready);
endinterface

interface gpcs_cfg_if;
  import gpcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/gait_phase_contact_scheduler.sv =====
// Gait phase contact scheduler: one result per tick, four legs with phase
// accumulators and start offsets. The block accepts one tick per clock cycle
// unless a stalled result backs up the pipeline, and passes each tick through the
// input register, increment register and result register; the 24x16 increment
// multiply sits in the first stage and the per-leg phase update in the second, and
// a stalled result does not stop the stages behind it from filling. Configuration
// writes are always taken; a write to a defined register clears all phases and sets
// all legs to start mode; write only while no tick is in flight.
`default_nettype none
`include "assert_macros.svh"

module gait_phase_contact_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpcs_cfg_if.sink    cfg_i,
  gpcs_tick_if.sink   tick_i,
  gpcs_res_if.source  res_o
);
  import gpcs_pkg::*;

  // Configuration registers.
  logic [StepFreqW-1:0]      cadence_q;
  logic [DutyW-1:0]          duty_q;
  logic signed [OffsetW-1:0] offset_q [NumLegs];
  logic                      cfg_clr;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    unique case (cfg_reg_e'(cfg_i.index))
      RegStepFreq, RegDuty, RegOffset0, RegOffset1, RegOffset2, RegOffset3:
        cfg_clr = cfg_i.valid;
      default: cfg_clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cadence_q <= StepFreqReset;
      duty_q    <= DutyReset;
      for (int i = 0; i < NumLegs; i++) begin
        offset_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        RegStepFreq: cadence_q   <= cfg_i.data[StepFreqW-1:0];
        RegDuty:     duty_q      <= cfg_i.data[DutyW-1:0];
        RegOffset0:  offset_q[0] <= $signed(cfg_i.data[OffsetW-1:0]);
        RegOffset1:  offset_q[1] <= $signed(cfg_i.data[OffsetW-1:0]);
        RegOffset2:  offset_q[2] <= $signed(cfg_i.data[OffsetW-1:0]);
        RegOffset3:  offset_q[3] <= $signed(cfg_i.data[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage loads when empty or when it drains.
  logic s1_valid_q, s2_valid_q, res_valid_q;
  logic out_en, s2_en, s1_en, s2_move, s1_move, tick_xfer;

  assign out_en    = !res_valid_q || res_o.ready;
  assign s2_en     = !s2_valid_q || out_en;
  assign s1_en     = !s1_valid_q || s2_en;
  assign s2_move   = s2_valid_q && out_en;
  assign s1_move   = s1_valid_q && s2_en;
  assign tick_i.ready = s1_en;
  assign tick_xfer = tick_i.valid && s1_en;

  // Stage 1: registered tick.
  logic [TickDtW-1:0] dt_q;
  logic               s1_run_q;

  // Stage 2: saturated phase increment.
  logic [ProdW-1:0] prod;
  logic [IncW-1:0]  inc_d, inc_q;
  logic             s2_run_q;

  assign prod  = ProdW'(dt_q) * ProdW'(cadence_q);
  assign inc_d = (|prod[ProdW-1:IncShift+IncW]) ? IncMax : prod[IncShift+IncW-1:IncShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= tick_i.valid;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_en) begin
        res_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_xfer) begin
      dt_q     <= tick_i.tick_dt;
      s1_run_q <= tick_i.run;
    end
    if (s1_move) begin
      inc_q    <= inc_d;
      s2_run_q <= s1_run_q;
    end
  end

  // Leg units.
  leg_ctrl_t leg_ctrl;
  leg_res_t  leg_res [NumLegs];
  leg_res_t  res_q   [NumLegs];

  assign leg_ctrl.upd = s2_move;
  assign leg_ctrl.clr = cfg_clr;
  assign leg_ctrl.run = s2_run_q;
  assign leg_ctrl.inc = inc_q;

  for (genvar g = 0; g < NumLegs; g++) begin : g_leg
    if (g < LegCount) begin : g_used
      gpcs_leg u_leg (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (leg_ctrl),
        .offset_i (offset_q[g]),
        .duty_i   (duty_q),
        .res_o    (leg_res[g])
      );
    end else begin : g_unused
      assign leg_res[g] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      for (int i = 0; i < NumLegs; i++) begin
        res_q[i] <= leg_res[i];
      end
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.contact_leg0 = res_q[0].contact;
  assign res_o.contact_leg1 = res_q[1].contact;
  assign res_o.contact_leg2 = res_q[2].contact;
  assign res_o.contact_leg3 = res_q[3].contact;
  assign res_o.phase_leg0   = res_q[0].phase;
  assign res_o.phase_leg1   = res_q[1].phase;
  assign res_o.phase_leg2   = res_q[2].phase;
  assign res_o.phase_leg3   = res_q[3].phase;

  // A tick leaving the increment stage always shows up as a result next cycle.
  `ASSERT_NEXT(a_s2_to_res, clk_i, rst_ni, s2_move, res_valid_q)
  // An empty input register always takes a tick.
  `ASSERT_IMPLIES(a_s1_empty_ready, clk_i, rst_ni, !s1_valid_q, tick_i.ready)
  // The phases of legs 0 and 3 never exceed one full cycle after the wrap.
  `ASSERT_IMPLIES(a_phase0_range, clk_i, rst_ni, res_valid_q,
                  (PhaseW+1)'(res_q[0].phase) <= OneCycle)
  `ASSERT_IMPLIES(a_phase3_range, clk_i, rst_ni, res_valid_q,
                  (PhaseW+1)'(res_q[3].phase) <= OneCycle)

endmodule

`default_nettype wire

// ===== design/gpcs_leg.sv =====
// One leg of the gait scheduler: phase accumulator, start-mode flag and
// contact decision. Depends on gpcs_pkg.
`default_nettype none

module gpcs_leg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gpcs_pkg::leg_ctrl_t                  ctrl_i,
  input  logic signed [gpcs_pkg::OffsetW-1:0]  offset_i,
  input  logic [gpcs_pkg::DutyW-1:0]           duty_i,
  output gpcs_pkg::leg_res_t                   res_o
);
  import gpcs_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              starting_q, starting_d;
  logic [PhaseW:0]   sum;
  logic [PhaseW-1:0] adv_phase;
  logic              adv_starting;
  logic signed [OffsetW:0] phase_s;
  logic signed [OffsetW:0] offset_s;
  logic              contact;

  always_comb begin
    sum = {1'b0, phase_q} + (PhaseW+1)'(ctrl_i.inc);
    // A phase of exactly one cycle is kept; only above it does it wrap.
    if (sum > OneCycle) begin
      sum = sum - OneCycle;
    end
    if (ctrl_i.run) begin
      adv_phase    = sum[PhaseW-1:0];
      adv_starting = starting_q;
    end else begin
      adv_phase    = '0;
      adv_starting = 1'b1;
    end

    phase_s  = $signed({{(OffsetW+1-PhaseW){1'b0}}, adv_phase});
    offset_s = $signed({offset_i[OffsetW-1], offset_i});

    phase_d    = adv_phase;
    starting_d = adv_starting;
    if (offset_i == OffsetDisabled) begin
      contact = 1'b0;
    end else if (adv_starting) begin
      contact = 1'b1;
      if (!(phase_s < offset_s)) begin
        starting_d = 1'b0;
        phase_d    = '0;
      end
    end else begin
      contact = (DutyW'(adv_phase) < duty_i);
    end
  end

  assign res_o.contact = contact;
  assign res_o.phase   = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      starting_q <= 1'b1;
    end else if (ctrl_i.clr) begin
      phase_q    <= '0;
      starting_q <= 1'b1;
    end else if (ctrl_i.upd) begin
      phase_q    <= phase_d;
      starting_q <= starting_d;
    end
  end

endmodule

`default_nettype wire
